### design/lrgp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrgp_pkg
// Shared widths, constants and types of the least round grid path unit.
// ----------------------------------------------------------------------------
package lrgp_pkg;

    localparam int VALUE_W          = 31;   // cell value width
    localparam int CFG_W            = 11;   // grid size register width
    localparam int TWOS_W           = 16;   // path sum of factors of 2
    localparam int FIVES_W          = 15;   // path sum of factors of 5
    localparam int OUT_W            = 15;   // result width
    localparam int TCNT_W           = 5;    // factors of 2 in one value, 0..30
    localparam int FCNT_W           = 4;    // factors of 5 in one value, 0..13
    localparam int DEFAULT_MAX_GRID = 1024;

    // Inverse of 5 modulo 2^31: multiplying an exact multiple of 5 by it gives
    // the quotient; any other value lands above FIVE_BOUND.
    localparam logic [VALUE_W-1:0] INV5       = 31'h4CCC_CCCD;
    localparam logic [VALUE_W-1:0] FIVE_BOUND = 31'h1999_9999;

    localparam logic [TWOS_W-1:0]  TWOS_MAX  = '1;
    localparam logic [FIVES_W-1:0] FIVES_MAX = '1;

    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } lrgp_state_t;

    typedef struct packed {
        logic              done;
        logic [TCNT_W-1:0] twos;
        logic [FCNT_W-1:0] fives;
    } fac_status_t;

endpackage

### design/lrgp_factor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrgp_factor
// Counts factors of 2 at once and factors of 5 one exact division per cycle.
// ----------------------------------------------------------------------------
module lrgp_factor (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        clear,
    input  logic [lrgp_pkg::VALUE_W-1:0] value,
    output lrgp_pkg::fac_status_t       status
);
    import lrgp_pkg::*;

    logic               busy_reg, busy_next;
    logic [VALUE_W-1:0] v_reg, v_next;
    logic [TCNT_W-1:0]  twos_reg, twos_next;
    logic [FCNT_W-1:0]  fives_reg, fives_next;
    logic [VALUE_W-1:0] quot;
    logic               divisible;

    function automatic logic [TCNT_W-1:0] count_twos(input logic [VALUE_W-1:0] v);
        logic [TCNT_W-1:0] n;
        logic              found;
        n     = '0;
        found = 1'b0;
        for (int i = 0; i < VALUE_W; i++) begin
            if (!found && v[i]) begin
                n     = TCNT_W'(i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // exact division test; zero never counts as divisible
    assign quot      = v_reg * INV5;
    assign divisible = (v_reg != '0) && (quot <= FIVE_BOUND);

    always_comb
    begin
        busy_next  = busy_reg;
        v_next     = v_reg;
        twos_next  = twos_reg;
        fives_next = fives_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            v_next     = value;
            twos_next  = count_twos(value);
            fives_next = '0;
        end
        else if (clear)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && divisible)
        begin
            v_next     = quot;
            fives_next = fives_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        twos_reg  <= twos_next;
        fives_reg <= fives_next;
    end

    // done holds once no factor of 5 is left, until cleared
    assign status.done  = busy_reg && !divisible;
    assign status.twos  = twos_reg;
    assign status.fives = fives_reg;

endmodule

### design/least_round_grid_path_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_round_grid_path_unit
// Fewest trailing zeros of a product along a monotone path through a grid.
// ----------------------------------------------------------------------------
// Usage:
//   Cells of an N x N grid arrive on the input channel (cell_value, in_valid,
//   in_stall) in row-major order. A transfer happens on a clock edge with
//   in_valid high and in_stall low. After the last cell of a grid one result
//   (fewest_trailing_zeros) is offered on the output channel; the receiver
//   holds it with out_stall. The next grid starts with the following cell.
//   The grid size is written through the configuration channel (grid_size,
//   cfg_valid, cfg_ready) while the unit is idle; a write drops any partial
//   grid. Size zero acts as one, sizes above MAX_GRID clamp to MAX_GRID.
// Timing:
//   The unit takes a cell only while idle and reads its row-store entries
//   as it takes it; it then does one exact divide step per factor of 5 in
//   the value (at most 13) and finishes the cell before it takes the next.
//   The result is offered from the edge that finishes the last cell. A
//   stalled result does not block the next cell; only a second result waits
//   until the first one has been taken.
// Reset:
//   Reset sets the grid size to 1 and starts a fresh grid. The row stores
//   are not cleared: every entry is written before it is read in a grid.
// ----------------------------------------------------------------------------
module least_round_grid_path_unit #(
    parameter int MAX_GRID = lrgp_pkg::DEFAULT_MAX_GRID
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [lrgp_pkg::VALUE_W-1:0] cell_value,
    input  logic                         in_valid,
    output logic                         in_stall,
    output logic [lrgp_pkg::OUT_W-1:0]   fewest_trailing_zeros,
    output logic                         out_valid,
    input  logic                         out_stall,
    input  logic [lrgp_pkg::CFG_W-1:0]   grid_size,
    input  logic                         cfg_valid,
    output logic                         cfg_ready
);
    import lrgp_pkg::*;

    localparam int IDX_W  = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
    localparam int SIZE_W = $clog2(MAX_GRID + 1);
    localparam int CMP_W  = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;

    // row stores: path minima of the previous row, updated in place
    logic [TWOS_W-1:0]  twos_mem  [MAX_GRID];
    logic [FIVES_W-1:0] fives_mem [MAX_GRID];
    logic [TWOS_W-1:0]  twos_rd_reg;
    logic [FIVES_W-1:0] fives_rd_reg;

    lrgp_state_t        state_reg, state_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [IDX_W-1:0]   row_reg, row_next;
    logic [IDX_W-1:0]   col_reg, col_next;
    logic [TWOS_W-1:0]  twos_left_reg, twos_left_next;
    logic [FIVES_W-1:0] fives_left_reg, fives_left_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   result_reg, result_next;

    fac_status_t        fac;
    logic               in_fire, cfg_fire, out_fire, out_free;
    logic               last_col, last_row, grid_last, step_fire;
    logic [CMP_W-1:0]   cfg_ext;
    logic [SIZE_W-1:0]  cfg_size;
    logic [TWOS_W-1:0]  twos_base, twos_sum;
    logic [FIVES_W-1:0] fives_base, fives_sum;
    logic [TWOS_W:0]    twos_wide;
    logic [FIVES_W:0]   fives_wide;
    logic [TWOS_W-1:0]  fives_as_twos, path_min;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE) || cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    lrgp_factor u_factor (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_fire),
        .clear  (step_fire),
        .value  (cell_value),
        .status (fac)
    );

    // position within the grid
    assign last_col  = ((SIZE_W'(col_reg) + 1'b1) == size_reg);
    assign last_row  = ((SIZE_W'(row_reg) + 1'b1) == size_reg);
    assign grid_last = last_col && last_row;

    // finish the cell once counts are in; a grid end needs room in the output
    assign step_fire = (state_reg == ST_WORK) && fac.done && (!grid_last || out_free);

    // clamp the written size into 1..MAX_GRID
    assign cfg_ext = CMP_W'(grid_size);
    always_comb
    begin
        if (cfg_ext == '0)
        begin
            cfg_size = SIZE_W'(1);
        end
        else if (cfg_ext > CMP_W'(MAX_GRID))
        begin
            cfg_size = SIZE_W'(MAX_GRID);
        end
        else
        begin
            cfg_size = SIZE_W'(cfg_ext);
        end
    end

    // pick the predecessor minima: corner, top row, left column or interior
    always_comb
    begin
        if (row_reg == '0 && col_reg == '0)
        begin
            twos_base  = '0;
            fives_base = '0;
        end
        else if (row_reg == '0)
        begin
            twos_base  = twos_left_reg;
            fives_base = fives_left_reg;
        end
        else if (col_reg == '0)
        begin
            twos_base  = twos_rd_reg;
            fives_base = fives_rd_reg;
        end
        else
        begin
            twos_base  = (twos_rd_reg <= twos_left_reg) ? twos_rd_reg : twos_left_reg;
            fives_base = (fives_rd_reg <= fives_left_reg) ? fives_rd_reg : fives_left_reg;
        end
    end

    // add this cell's counts, saturating at the store width
    assign twos_wide  = {1'b0, twos_base} + (TWOS_W + 1)'(fac.twos);
    assign fives_wide = {1'b0, fives_base} + (FIVES_W + 1)'(fac.fives);
    assign twos_sum   = twos_wide[TWOS_W] ? TWOS_MAX : twos_wide[TWOS_W-1:0];
    assign fives_sum  = fives_wide[FIVES_W] ? FIVES_MAX : fives_wide[FIVES_W-1:0];

    assign fives_as_twos = TWOS_W'(fives_sum);
    assign path_min      = (twos_sum <= fives_as_twos) ? twos_sum : fives_as_twos;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                if (step_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // grid position, left minima and result slot
    always_comb
    begin
        size_next       = size_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        twos_left_next  = twos_left_reg;
        fives_left_next = fives_left_reg;
        out_valid_next  = out_valid_reg && !out_fire;
        result_next     = result_reg;
        if (cfg_fire)
        begin
            // drop the partial grid
            size_next       = cfg_size;
            row_next        = '0;
            col_next        = '0;
            twos_left_next  = '0;
            fives_left_next = '0;
        end
        else if (step_fire)
        begin
            twos_left_next  = twos_sum;
            fives_left_next = fives_sum;
            if (!last_col)
            begin
                col_next = col_reg + 1'b1;
            end
            else if (!last_row)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next        = '0;
                row_next        = '0;
                twos_left_next  = '0;
                fives_left_next = '0;
                out_valid_next  = 1'b1;
                result_next     = path_min[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            size_reg       <= SIZE_W'(1);
            row_reg        <= '0;
            col_reg        <= '0;
            twos_left_reg  <= '0;
            fives_left_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            size_reg       <= size_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            twos_left_reg  <= twos_left_next;
            fives_left_reg <= fives_left_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // read the column's entry when the cell arrives, write it back when done;
    // the two never meet on one entry since only one cell is in flight
    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            twos_mem[col_reg] <= twos_sum;
        end
        if (in_fire)
        begin
            twos_rd_reg <= twos_mem[col_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            fives_mem[col_reg] <= fives_sum;
        end
        if (in_fire)
        begin
            fives_rd_reg <= fives_mem[col_reg];
        end
    end

    assign out_valid             = out_valid_reg;
    assign fewest_trailing_zeros = result_reg;

endmodule

### design/lrgp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrgp_checker
// Port-level checks of the least round grid path unit, bound to the top level.
// ----------------------------------------------------------------------------
module lrgp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [lrgp_pkg::OUT_W-1:0]   fewest_trailing_zeros,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         cfg_valid,
    input logic                         cfg_ready
);
    import lrgp_pkg::*;

    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(fewest_trailing_zeros))
        else $error("result changed or dropped while stalled");

    // one cell at a time: a transfer closes the input for the next cycle
    a_one_cell: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after a cell transfer");

    // a configuration write never shares an edge with a cell transfer
    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> in_stall)
        else $error("cell taken together with a configuration write");

    // a new result only comes out of a cell in progress
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a cell in progress");

endmodule

bind least_round_grid_path_unit lrgp_checker u_lrgp_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .fewest_trailing_zeros (fewest_trailing_zeros),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready)
);

### tb/tb_least_round_grid_path_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_least_round_grid_path_unit
// Self-checking bench for the least round grid path unit: streams grids of
// cell values under random idling and stalls, predicts the fewest trailing
// zeros of every finished grid and compares each result transfer with it.
// ----------------------------------------------------------------------------
module tb_least_round_grid_path_unit;
    import lrgp_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    // Leave slack so that a dropped partial cell has surely left the pipe
    // before a write.
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int CELL_TARGET   = 1350;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_GAP       = 16;

    // ------------------------------------------------------------------------
    // Path-minimum predictor and store of expected results
    // ------------------------------------------------------------------------
    class zero_path_scoreboard;
        logic [CFG_W-1:0]   size_reg;
        logic [TWOS_W-1:0]  twos_row  [DEFAULT_MAX_GRID];
        logic [FIVES_W-1:0] fives_row [DEFAULT_MAX_GRID];
        int unsigned        row;
        int unsigned        col;
        logic [TWOS_W-1:0]  twos_left;
        logic [FIVES_W-1:0] fives_left;
        logic [OUT_W-1:0]   fewest_q [$];
        int unsigned        errors;

        function new();
            size_reg   = 1;
            row        = 0;
            col        = 0;
            twos_left  = '0;
            fives_left = '0;
            errors     = 0;
        endfunction

        // Size as the unit sees it: zero acts as one, large sizes clamp.
        function int unsigned side();
            if (size_reg == 0)
                return 1;
            if (size_reg > DEFAULT_MAX_GRID)
                return DEFAULT_MAX_GRID;
            return size_reg;
        endfunction

        function int unsigned grid_cells();
            return side() * side();
        endfunction

        // A register write drops the partial grid.
        function void set_size(logic [CFG_W-1:0] n);
            size_reg   = n;
            row        = 0;
            col        = 0;
            twos_left  = '0;
            fives_left = '0;
        endfunction

        function void note_cell(logic [VALUE_W-1:0] v);
            logic [VALUE_W-1:0] rest;
            int unsigned        twos;
            int unsigned        fives;
            int unsigned        n;
            logic [TWOS_W-1:0]  t_base;
            logic [FIVES_W-1:0] f_base;
            logic [TWOS_W:0]    t_sum;
            logic [FIVES_W:0]   f_sum;
            logic [OUT_W-1:0]   best;

            n     = side();
            twos  = 0;
            rest  = v;
            while (rest != 0 && !rest[0])
            begin
                rest = rest >> 1;
                twos++;
            end
            fives = 0;
            rest  = v;
            while (rest != 0 && rest % 5 == 0)
            begin
                rest = rest / 5;
                fives++;
            end

            // Best predecessor: nothing at the corner, left on the top row,
            // above on the left column, else the smaller of the two.
            if (row == 0 && col == 0)
            begin
                t_base = '0;
                f_base = '0;
            end
            else if (row == 0)
            begin
                t_base = twos_left;
                f_base = fives_left;
            end
            else if (col == 0)
            begin
                t_base = twos_row[col];
                f_base = fives_row[col];
            end
            else
            begin
                t_base = (twos_row[col] <= twos_left) ? twos_row[col] : twos_left;
                f_base = (fives_row[col] <= fives_left) ? fives_row[col] : fives_left;
            end

            t_sum      = {1'b0, t_base} + (TWOS_W + 1)'(twos);
            f_sum      = {1'b0, f_base} + (FIVES_W + 1)'(fives);
            twos_left  = (t_sum > TWOS_MAX) ? TWOS_MAX : t_sum[TWOS_W-1:0];
            fives_left = (f_sum > FIVES_MAX) ? FIVES_MAX : f_sum[FIVES_W-1:0];
            twos_row[col]  = twos_left;
            fives_row[col] = fives_left;

            if (col + 1 < n)
                col++;
            else if (row + 1 < n)
            begin
                row++;
                col = 0;
            end
            else
            begin
                best = (twos_left <= fives_left) ? twos_left[OUT_W-1:0] : fives_left;
                fewest_q.push_back(best);
                row        = 0;
                col        = 0;
                twos_left  = '0;
                fives_left = '0;
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (fewest_q.size() == 0)
            begin
                $display("%0t: unexpected fewest_trailing_zeros, expected none, actual %0d",
                         $time, got);
                errors++;
            end
            else
            begin
                want = fewest_q.pop_front();
                if (got !== want)
                begin
                    $display("%0t: fewest_trailing_zeros mismatch, expected %0d, actual %0d",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int unsigned pending();
            return fewest_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and shared state
    // ------------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n;
    logic [VALUE_W-1:0]  cell_value;
    logic                in_valid;
    logic                in_stall;
    logic [OUT_W-1:0]    fewest_trailing_zeros;
    logic                out_valid;
    logic                out_stall;
    logic [CFG_W-1:0]    grid_size;
    logic                cfg_valid;
    logic                cfg_ready;

    zero_path_scoreboard book = new();
    int unsigned         cells_sent  = 0;
    int unsigned         cycle_count = 0;
    bit                  steady      = 1'b0;  // no idling on either side
    bit                  hold_req    = 1'b0;  // ask the sink for one long hold

    always #CLK_HALF clk = ~clk;

    least_round_grid_path_unit #(
        .MAX_GRID (DEFAULT_MAX_GRID)
    ) u_top (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cell_value            (cell_value),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .fewest_trailing_zeros (fewest_trailing_zeros),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .grid_size             (grid_size),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready)
    );

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one cell after a random gap and hold it until the transfer.
    // When the gap is zero, valid stays high straight from the last transfer.
    task automatic send_cell(input logic [VALUE_W-1:0] v);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cell_value <= v;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        book.note_cell(v);
        cells_sent++;
    endtask

    // Write the grid size; only called with the unit idle.
    task automatic write_grid_size(input logic [CFG_W-1:0] n);
        cfg_valid <= 1'b1;
        grid_size <= n;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        book.set_size(n);
    endtask

    // Drop valid, wait for every expected result, then let any cell that
    // produces no result run out of the pipe.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Half are products of chosen powers of 2 and 5 times a random factor, so
    // that both counts span their whole range; the rest plain random values
    // and the extremes.
    function automatic logic [VALUE_W-1:0] pick_cell();
        int unsigned k;
        int unsigned a;
        int unsigned b;
        logic [63:0] p;
        logic [63:0] lim;
        logic [63:0] m;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 1;
        if (k == 1)
            return {VALUE_W{1'b1}};
        if (k <= 4)
        begin
            m = $urandom() & 32'h7FFF_FFFF;
            return (m == 0) ? 1 : m[VALUE_W-1:0];
        end
        a = $urandom_range(0, 30);
        b = $urandom_range(0, 13);
        p = 1;
        repeat (a) p = p * 2;
        repeat (b) p = p * 5;
        // Strip factors until the product fits the field.
        while (p > 64'h7FFF_FFFF)
        begin
            if (p % 5 == 0 && (p % 2 != 0 || $urandom_range(0, 1) == 1))
                p = p / 5;
            else
                p = p / 2;
        end
        lim = 64'h7FFF_FFFF / p;
        m   = 1 + ($urandom() % lim);
        p   = p * m;
        return p[VALUE_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side: random stall before each result, one long hold on request
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned pause;
        out_stall <= 1'b1;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                // Hold off long enough that a result waits, a second one
                // backs up behind it and the input stalls.
                hold_req = 1'b0;
                pause    = HOLD_CYCLES;
            end
            else
                pause = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (pause > 0)
            begin
                out_stall <= 1'b1;
                repeat (pause) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
            book.check_result(fewest_trailing_zeros);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if the cycle count runs past the limit
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned      total;
        int unsigned      grids;
        int unsigned      k;
        logic [CFG_W-1:0] n;

        rst_n      <= 1'b0;
        cell_value <= '0;
        in_valid   <= 1'b0;
        grid_size  <= '0;
        cfg_valid  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size is one, so every cell is a whole grid. Cover the value
        // extremes, a zero cell (counted like one) and equal twos and fives.
        send_cell(1);
        send_cell({VALUE_W{1'b1}});
        send_cell(0);
        send_cell(31'd1_000_000_000);
        wait_idle();

        // Size zero acts as one; take the most fives and the most twos.
        write_grid_size(0);
        send_cell(31'd1_220_703_125);
        send_cell(31'd1_073_741_824);
        wait_idle();

        // Partial grids dropped by the next write, including the largest
        // size and a size that clamps to it.
        write_grid_size(3);
        repeat (4) send_cell(pick_cell());
        wait_idle();
        write_grid_size({CFG_W{1'b1}});
        repeat (3) send_cell(pick_cell());
        wait_idle();
        write_grid_size(CFG_W'(DEFAULT_MAX_GRID));
        repeat (2) send_cell(pick_cell());
        wait_idle();

        // Full 2x2 grid right after the drop: must start at the corner.
        write_grid_size(2);
        send_cell(31'd1_073_741_824);
        send_cell(31'd1_220_703_125);
        send_cell(31'd1_000_000_000);
        send_cell(31'd40);
        wait_idle();

        // Back pressure: single-cell grids offered without gaps while the
        // sink holds off, so results pile up and the input stalls.
        write_grid_size(1);
        steady   = 1'b1;
        hold_req = 1'b1;
        repeat (40) send_cell(pick_cell());
        wait_idle();

        // Random grids: mostly small sizes, a few larger ones and size zero,
        // one to three grids per setting, now and then a dropped partial grid.
        while (cells_sent < CELL_TARGET)
        begin
            k = $urandom_range(0, 39);
            if (k == 0)
                n = '0;
            else if (k == 1)
                n = CFG_W'($urandom_range(9, 16));
            else
                n = CFG_W'($urandom_range(1, 8));
            write_grid_size(n);
            steady = ($urandom_range(0, 4) == 0);
            grids  = $urandom_range(1, 3);
            repeat (grids)
            begin
                total = book.grid_cells();
                if (total > 1 && $urandom_range(0, 9) == 0)
                    total = $urandom_range(1, total - 1);
                repeat (total) send_cell(pick_cell());
            end
            wait_idle();
        end

        if (book.errors == 0 && book.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### least_round_grid_path_unit.f
design/lrgp_pkg.sv
design/lrgp_factor.sv
design/least_round_grid_path_unit.sv
design/lrgp_checker.sv
tb/tb_least_round_grid_path_unit.sv
